// ----- rtl/core/escaped_packet_deframer_core_macros.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef ESCAPED_PACKET_DEFRAMER_CORE_MACROS_SVH
`define ESCAPED_PACKET_DEFRAMER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define EPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define EPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  `EPD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/core/epd_pkg.sv -----
// Types and constants of the escaped packet deframer.
package epd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 10;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ByteW-1:0] BYTE_MAX    = 8'hFF;
  localparam logic [LenW-1:0]  MAX_LEN_RST = 10'd255;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TO   = 3'd1,
    PH_FROM = 3'd2,
    PH_CMD  = 3'd3,
    PH_DATA = 3'd4
  } epd_phase_e;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_SUM   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_MALFORMED = 2'd3
  } epd_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER  = 3'd0,
    CFG_ESCAPE  = 3'd1,
    CFG_END     = 3'd2,
    CFG_OWN     = 3'd3,
    CFG_MAX_LEN = 3'd4
  } epd_cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             line_error;
  } epd_in_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] source_address;
    logic [ByteW-1:0] command;
    logic [1:0]       status;
    logic [LenW-1:0]  data_count;
  } epd_out_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } epd_buf_stat_t;

endpackage

// ----- rtl/core/epd_out_buf.sv -----
// Two-entry result buffer: output register plus skid register.
module epd_out_buf
  import epd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  epd_out_t      push_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output epd_out_t      out_data_o,
  output epd_buf_stat_t stat_o
);

  logic     out_v_q, out_v_d;
  logic     skid_v_q, skid_v_d;
  epd_out_t out_q, out_d;
  epd_out_t skid_q, skid_d;
  logic     pop;

  assign pop = out_v_q && out_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        // advance the waiting item, park a new one behind it
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = push_i;
        skid_d   = push_data_i;
      end else begin
        out_v_d = push_i;
        out_d   = push_data_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_v_q;
  assign out_data_o       = out_q;
  assign stat_o.out_full  = out_v_q;
  assign stat_o.skid_full = skid_v_q;

endmodule

// ----- rtl/core/escaped_packet_deframer_core.sv -----
// Byte-stuffed packet deframer with additive checksum: top level.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one received byte
// per item with its line error flag; flagged bytes are dropped. Output
// channel (out_valid_o/out_ready_i/out_data_o) gives unescaped payload
// bytes (kind 0) and one status item (kind 1) at each body end byte or overflow.
// Configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i)
// writes header, escape, end, own address and maximum body length; it is
// always ready; the user must write it only while the block is idle; not enforced.
// An item is taken into an input register, decoded and its result written
// to the output register, or to the skid register while the output register
// is occupied. One item per cycle is sustained while the result buffer has room,
// bounded by the single decode stage between input and result registers.
// When the receiver stalls, a skid register takes one more result; with
// both occupied the decode stage holds and in_ready_o falls once the
// input register is full.
// Reset returns the block to header hunting with all counters and the
// checksum cleared; configuration returns to its reset values.
`include "escaped_packet_deframer_core_macros.svh"

module escaped_packet_deframer_core
  import epd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  epd_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output epd_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [LenW-1:0]    cfg_data_i
);

  // configuration
  logic [ByteW-1:0] header_q, escape_q, end_q, own_q;
  logic [LenW-1:0]  max_len_q;

  // input register
  logic    in_v_q;
  epd_in_t in_q;

  // frame state
  epd_phase_e       phase_q, phase_d;
  logic             esc_q, esc_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             held_v_q, held_v_d;
  logic [LenW-1:0]  raw_q, raw_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] sender_q, sender_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [LenW-1:0]  payload_q, payload_d;

  epd_buf_stat_t    buf_stat;
  logic             adv;
  logic             step;
  logic             push;
  epd_out_t         res;
  logic [ByteW-1:0] rx_b;
  logic [ByteW-1:0] val;
  logic             take;
  logic             hdr_start;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= '0;
      escape_q  <= '0;
      end_q     <= '0;
      own_q     <= '0;
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HEADER:  header_q  <= cfg_data_i[ByteW-1:0];
        CFG_ESCAPE:  escape_q  <= cfg_data_i[ByteW-1:0];
        CFG_END:     end_q     <= cfg_data_i[ByteW-1:0];
        CFG_OWN:     own_q     <= cfg_data_i[ByteW-1:0];
        CFG_MAX_LEN: max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode stage moves only while the result buffer has room
  assign adv        = !(buf_stat.out_full && buf_stat.skid_full);
  assign in_ready_o = !in_v_q || adv;
  assign step       = in_v_q && adv && !in_q.line_error;
  assign rx_b       = in_q.rx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    held_d    = held_q;
    held_v_d  = held_v_q;
    raw_d     = raw_q;
    sum_d     = sum_q;
    sender_d  = sender_q;
    cmd_d     = cmd_q;
    payload_d = payload_q;
    push      = 1'b0;
    val       = rx_b;
    take      = 1'b0;
    hdr_start = 1'b0;
    res                = '0;
    res.source_address = sender_q;
    res.command        = cmd_q;
    if (step) begin
      unique case (phase_q)
        PH_TO: begin
          if (rx_b == own_q) begin
            sum_d   = sum_q + rx_b;
            phase_d = PH_FROM;
          end else begin
            hdr_start = 1'b1;
          end
        end
        PH_FROM: begin
          sender_d = rx_b;
          sum_d    = sum_q + rx_b;
          phase_d  = PH_CMD;
        end
        PH_CMD: begin
          cmd_d   = rx_b;
          sum_d   = sum_q + rx_b;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          if (rx_b == end_q) begin
            push           = 1'b1;
            res.kind       = KIND_STATUS;
            res.data_count = payload_q;
            if (esc_q || !held_v_q) begin
              res.status = ST_MALFORMED;
            end else if (sum_q == held_q) begin
              res.status = ST_GOOD;
            end else begin
              res.status = ST_BAD_SUM;
            end
            phase_d = PH_HUNT;
            esc_d   = 1'b0;
          end else if (raw_q >= max_len_q) begin
            // abort, then test the same byte as a header
            push           = 1'b1;
            res.kind       = KIND_STATUS;
            res.status     = ST_OVERFLOW;
            res.data_count = payload_q;
            hdr_start      = 1'b1;
          end else begin
            raw_d = raw_q + 1'b1;
            if (esc_q) begin
              esc_d = 1'b0;
              val   = BYTE_MAX - rx_b;
              take  = 1'b1;
            end else if (rx_b == escape_q) begin
              esc_d = 1'b1;
            end else begin
              take = 1'b1;
            end
          end
          if (take) begin
            // release the held byte; the newest stays back as a checksum candidate
            if (held_v_q) begin
              push          = 1'b1;
              res.kind      = KIND_DATA;
              res.data_byte = held_q;
              sum_d         = sum_q + held_q;
              payload_d     = payload_q + 1'b1;
            end
            held_d   = val;
            held_v_d = 1'b1;
          end
        end
        default: hdr_start = 1'b1;
      endcase
      if (hdr_start) begin
        if (rx_b == header_q) begin
          phase_d   = PH_TO;
          sum_d     = rx_b;
          raw_d     = '0;
          payload_d = '0;
          esc_d     = 1'b0;
          held_v_d  = 1'b0;
          held_d    = '0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      esc_q     <= 1'b0;
      held_q    <= '0;
      held_v_q  <= 1'b0;
      raw_q     <= '0;
      sum_q     <= '0;
      sender_q  <= '0;
      cmd_q     <= '0;
      payload_q <= '0;
    end else begin
      phase_q   <= phase_d;
      esc_q     <= esc_d;
      held_q    <= held_d;
      held_v_q  <= held_v_d;
      raw_q     <= raw_d;
      sum_q     <= sum_d;
      sender_q  <= sender_d;
      cmd_q     <= cmd_d;
      payload_q <= payload_d;
    end
  end

  epd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (buf_stat)
  );

  `EPD_ASSERT_IMPL(a_push_has_room, push, !buf_stat.skid_full, "result pushed into full buffer")
  `EPD_ASSERT_IMPL(a_stall_means_full, !in_ready_o, in_v_q && buf_stat.skid_full,
                   "input stalled without full buffer")
  `EPD_ASSERT(a_payload_le_raw, payload_q <= raw_q, "payload count exceeds raw body count")
  `EPD_ASSERT_IMPL(a_data_fields_clear, out_valid_o && (out_data_o.kind == KIND_DATA),
                   (out_data_o.status == ST_GOOD) && (out_data_o.data_count == '0),
                   "data item carries status fields")

endmodule
